>>> rtl/mcna_pkg.sv
// ----------------------------------------------------------------------------
// mcna_pkg: shared types and constants of the MIDI channel note allocator
// Field widths, event kind codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package mcna_pkg;

	localparam int CHANNELS = 16;
	localparam int IDX_W    = $clog2(CHANNELS);

	localparam int KIND_W = 2;
	localparam int CH_W   = 4;
	localparam int NOTE_W = 7;
	localparam int VEL_W  = 7;
	localparam int HELD_W = 8;
	localparam int ACT_W  = 5;

	localparam logic [HELD_W-1:0] FREE_NOTE  = 8'hFF;
	localparam logic [CH_W-1:0]   DRUM_RESET = 4'd9;

	localparam logic [KIND_W-1:0] KIND_NOTE_ON  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_NOTE_OFF = 2'd1;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;      // take the input transfer into the work registers
		logic idx_own;   // point the scan index at the event's channel
		logic idx_zero;  // point the scan index at channel 0
		logic idx_next;  // advance scan index (wraps) and step count
		logic alloc;     // store the note at the scan index
		logic free_ent;  // clear the entry at the scan index
		logic nofree;    // flag the result as having found no free channel
		logic emit;      // load the output register
	} dp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic pass;       // event leaves the state untouched
		logic note_on;    // note-on with nonzero velocity
		logic ent_free;   // entry at scan index is free
		logic ent_match;  // entry holds the moved note of this origin and number
		logic ent_skip;   // scan index is the drum channel
		logic last;       // final step of a scan
		logic obuf_free;  // output register can take a result this cycle
	} dp_sts_t;

endpackage

>>> rtl/mcna_dpath.sv
// ----------------------------------------------------------------------------
// mcna_dpath: channel table, scan index and result registers
// Holds the per-channel note table, the active count and the output stage.
// ----------------------------------------------------------------------------
module mcna_dpath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mcna_pkg::dp_cmd_t            cmd,
	output mcna_pkg::dp_sts_t            sts,
	input  logic [mcna_pkg::KIND_W-1:0]  event_kind,
	input  logic [mcna_pkg::CH_W-1:0]    channel,
	input  logic [mcna_pkg::NOTE_W-1:0]  note_number,
	input  logic [mcna_pkg::VEL_W-1:0]   velocity,
	input  logic                         cfg_valid,
	input  logic [mcna_pkg::CH_W-1:0]    cfg_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [mcna_pkg::CH_W-1:0]    out_channel,
	output logic                         moved,
	output logic                         no_free_channel,
	output logic [mcna_pkg::ACT_W-1:0]   active_notes
);

	logic [mcna_pkg::KIND_W-1:0] kind_q;
	logic [mcna_pkg::CH_W-1:0]   ch_q;
	logic [mcna_pkg::NOTE_W-1:0] note_q;
	logic [mcna_pkg::VEL_W-1:0]  vel_q;
	logic [mcna_pkg::CH_W-1:0]   drum_q;

	logic [mcna_pkg::IDX_W-1:0]  idx_q;
	logic [mcna_pkg::IDX_W-1:0]  cnt_q;

	logic [mcna_pkg::HELD_W-1:0] held_q [mcna_pkg::CHANNELS];
	logic [mcna_pkg::CH_W-1:0]   orig_q [mcna_pkg::CHANNELS];
	logic                        mark_q [mcna_pkg::CHANNELS];
	logic [mcna_pkg::ACT_W-1:0]  active_q;

	logic [mcna_pkg::CH_W-1:0]   res_ch_q;
	logic                        res_mv_q;
	logic                        res_nf_q;

	logic [mcna_pkg::HELD_W-1:0] ent_held;
	logic [mcna_pkg::CH_W-1:0]   ent_orig;
	logic                        ent_mark;
	logic [mcna_pkg::CH_W-1:0]   idx_ch;

	assign ent_held = held_q[idx_q];
	assign ent_orig = orig_q[idx_q];
	assign ent_mark = mark_q[idx_q];
	assign idx_ch   = mcna_pkg::CH_W'(idx_q);

	always_comb begin
		sts.pass      = (kind_q != mcna_pkg::KIND_NOTE_ON && kind_q != mcna_pkg::KIND_NOTE_OFF)
			|| (ch_q == drum_q)
			|| (mcna_pkg::ACT_W'(ch_q) >= mcna_pkg::ACT_W'(mcna_pkg::CHANNELS));
		sts.note_on   = (kind_q == mcna_pkg::KIND_NOTE_ON) && (vel_q != '0);
		sts.ent_free  = (ent_held == mcna_pkg::FREE_NOTE);
		sts.ent_match = (ent_held != mcna_pkg::FREE_NOTE) && ent_mark && (ent_orig == ch_q)
			&& (ent_held == mcna_pkg::HELD_W'(note_q));
		sts.ent_skip  = (idx_ch == drum_q);
		sts.last      = (cnt_q == mcna_pkg::IDX_W'(mcna_pkg::CHANNELS - 1));
		sts.obuf_free = !out_valid || !out_stall;
	end

	// Drum channel register; the user must write it only while idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drum_q <= mcna_pkg::DRUM_RESET;
		end else if (cfg_valid) begin
			drum_q <= cfg_data;
		end
	end

	// Work registers for the event in flight
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= event_kind;
			ch_q   <= channel;
			note_q <= note_number;
			vel_q  <= velocity;
		end
	end

	// Scan index and step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			cnt_q <= '0;
		end else if (cmd.idx_own) begin
			idx_q <= mcna_pkg::IDX_W'(ch_q);
			cnt_q <= '0;
		end else if (cmd.idx_zero) begin
			idx_q <= '0;
			cnt_q <= '0;
		end else if (cmd.idx_next) begin
			idx_q <= (idx_q == mcna_pkg::IDX_W'(mcna_pkg::CHANNELS - 1)) ? '0 : idx_q + 1'b1;
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// Channel table and active count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mcna_pkg::CHANNELS; i++) begin
				held_q[i] <= mcna_pkg::FREE_NOTE;
				orig_q[i] <= '0;
				mark_q[i] <= 1'b0;
			end
			active_q <= '0;
		end else if (cmd.alloc) begin
			held_q[idx_q] <= mcna_pkg::HELD_W'(note_q);
			orig_q[idx_q] <= ch_q;
			mark_q[idx_q] <= (idx_ch != ch_q);
			active_q      <= active_q + 1'b1;
		end else if (cmd.free_ent) begin
			held_q[idx_q] <= mcna_pkg::FREE_NOTE;
			orig_q[idx_q] <= '0;
			mark_q[idx_q] <= 1'b0;
			if (ent_held != mcna_pkg::FREE_NOTE) begin
				active_q <= active_q - 1'b1;
			end
		end
	end

	// Result being built; a table write at another channel means the event moved
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_ch_q <= channel;
			res_mv_q <= 1'b0;
			res_nf_q <= 1'b0;
		end else if (cmd.alloc || cmd.free_ent) begin
			res_ch_q <= idx_ch;
			res_mv_q <= (idx_ch != ch_q);
		end else if (cmd.nofree) begin
			res_nf_q <= 1'b1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_channel     <= res_ch_q;
			moved           <= res_mv_q;
			no_free_channel <= res_nf_q;
			active_notes    <= active_q;
		end
	end

	a_active_bound: assert property (@(posedge clk) disable iff (!arst_n)
		active_q <= mcna_pkg::ACT_W'(mcna_pkg::CHANNELS))
		else $error("active count exceeds channel count");

	a_alloc_not_drum: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc |-> (idx_ch != drum_q) && sts.ent_free)
		else $error("note stored on drum or busy channel");

	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.obuf_free)
		else $error("result overwrote a waiting transfer");

endmodule

>>> rtl/mcna_ctrl.sv
// ----------------------------------------------------------------------------
// mcna_ctrl: sequencing state machine of the note allocator
// Steps the datapath through own-channel checks and channel scans.
// ----------------------------------------------------------------------------
module mcna_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  mcna_pkg::dp_sts_t   sts,
	output mcna_pkg::dp_cmd_t   cmd
);

	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_DECIDE   = 7'b0000010,
		ST_OWN_ON   = 7'b0000100,
		ST_SCAN_ON  = 7'b0001000,
		ST_SCAN_OFF = 7'b0010000,
		ST_OWN_OFF  = 7'b0100000,
		ST_RESULT   = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (sts.pass) begin
					state_d = ST_RESULT;
				end else if (sts.note_on) begin
					cmd.idx_own = 1'b1;
					state_d     = ST_OWN_ON;
				end else begin
					cmd.idx_zero = 1'b1;
					state_d      = ST_SCAN_OFF;
				end
			end
			ST_OWN_ON: begin
				if (sts.ent_free) begin
					cmd.alloc = 1'b1;
					state_d   = ST_RESULT;
				end else begin
					cmd.idx_next = 1'b1;
					state_d      = ST_SCAN_ON;
				end
			end
			ST_SCAN_ON: begin
				if (!sts.ent_skip && sts.ent_free) begin
					cmd.alloc = 1'b1;
					state_d   = ST_RESULT;
				end else if (sts.last) begin
					cmd.nofree = 1'b1;
					state_d    = ST_RESULT;
				end else begin
					cmd.idx_next = 1'b1;
				end
			end
			ST_SCAN_OFF: begin
				if (sts.ent_match) begin
					cmd.free_ent = 1'b1;
					state_d      = ST_RESULT;
				end else if (sts.last) begin
					cmd.idx_own = 1'b1;
					state_d     = ST_OWN_OFF;
				end else begin
					cmd.idx_next = 1'b1;
				end
			end
			ST_OWN_OFF: begin
				cmd.free_ent = 1'b1;
				state_d      = ST_RESULT;
			end
			ST_RESULT: begin
				if (sts.obuf_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_busy_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second transfer taken while an event is in flight");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RESULT && !sts.obuf_free |=> state_q == ST_RESULT)
		else $error("result dropped while output stalled");

	a_one_table_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.alloc && cmd.free_ent))
		else $error("store and clear issued together");

endmodule

>>> rtl/midi_channel_note_allocator_top.sv
// ----------------------------------------------------------------------------
// midi_channel_note_allocator_top: MIDI channel note allocator
// One MIDI event in, one routed event out, at most one note per channel.
// ----------------------------------------------------------------------------
// Each accepted event yields exactly one result. A note-on with nonzero
// velocity lands on its own channel when that channel is free; otherwise it
// moves to the next free channel in round-robin order, skipping the drum
// channel, and is flagged moved. If every channel is busy it stays put with
// no_free_channel set and the table unchanged. A note-off (or velocity-0
// note-on) frees the lowest channel holding a moved note of the same origin
// and number, reporting that channel; failing that it frees its own channel.
// Other events, drum channel events and channels beyond the table pass
// through. The scan visits one table entry per cycle through a single
// read port. A new event is taken once the previous result is in the
// output register, even if that result has not yet been transferred.
// The drum channel register (reset 9) is written through the cfg channel,
// which is always ready; write it only while the block is idle.
// The active_notes field counts held channels after the event is applied.
// ----------------------------------------------------------------------------
module midi_channel_note_allocator_top (
	input  logic                         clk,
	input  logic                         arst_n,
	// event input channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [mcna_pkg::KIND_W-1:0]  event_kind,
	input  logic [mcna_pkg::CH_W-1:0]    channel,
	input  logic [mcna_pkg::NOTE_W-1:0]  note_number,
	input  logic [mcna_pkg::VEL_W-1:0]   velocity,
	// result channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [mcna_pkg::CH_W-1:0]    out_channel,
	output logic                         moved,
	output logic                         no_free_channel,
	output logic [mcna_pkg::ACT_W-1:0]   active_notes,
	// drum channel register write
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [mcna_pkg::CH_W-1:0]    cfg_data
);

	mcna_pkg::dp_cmd_t cmd;
	mcna_pkg::dp_sts_t sts;

	// The drum register write channel is always ready
	assign cfg_ready = 1'b1;

	// Sequencer: one event at a time, scan steps issued as commands
	mcna_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Channel table, scan index, drum register and output stage
	mcna_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.event_kind      (event_kind),
		.channel         (channel),
		.note_number     (note_number),
		.velocity        (velocity),
		.cfg_valid       (cfg_valid && cfg_ready),
		.cfg_data        (cfg_data),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_channel     (out_channel),
		.moved           (moved),
		.no_free_channel (no_free_channel),
		.active_notes    (active_notes)
	);

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: MIDI channel note allocator
// A directed table covers pass-through, moves, wraparound, the full table and
// note-off matching. Random phases follow under several drum channel settings.
// A predictor or a typed row checks every result. Bursty input, patterned stall.
// ----------------------------------------------------------------------------
module testbench;

	// Event kinds the package leaves unnamed
	localparam logic [mcna_pkg::KIND_W-1:0] KIND_OTHER = 2'd2;
	localparam logic [mcna_pkg::KIND_W-1:0] KIND_RSVD  = 2'd3;

	localparam int DIR_ROWS     = 25;
	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 238;
	localparam int DRAIN_CYCLES = 25;   // beyond the worst per-event latency
	localparam int TIMEOUT      = 4000000;

	typedef struct packed {
		logic [mcna_pkg::CH_W-1:0]  ch;
		logic                       mv;
		logic                       nofree;
		logic [mcna_pkg::ACT_W-1:0] act;
	} route_t;

	typedef struct packed {
		logic [mcna_pkg::KIND_W-1:0] kind;
		logic [mcna_pkg::CH_W-1:0]   ch;
		logic [mcna_pkg::NOTE_W-1:0] note;
		logic [mcna_pkg::VEL_W-1:0]  vel;
		logic                        typed;   // row carries its own expected route
		route_t                      want;
	} stim_row_t;

	typedef struct packed {
		logic [mcna_pkg::CH_W-1:0]   ch;
		logic [mcna_pkg::NOTE_W-1:0] note;
	} played_t;

	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_COMB} stall_mode_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [mcna_pkg::KIND_W-1:0]   event_kind = '0;
	logic [mcna_pkg::CH_W-1:0]     channel = '0;
	logic [mcna_pkg::NOTE_W-1:0]   note_number = '0;
	logic [mcna_pkg::VEL_W-1:0]    velocity = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [mcna_pkg::CH_W-1:0]     out_channel;
	logic                          moved;
	logic                          no_free_channel;
	logic [mcna_pkg::ACT_W-1:0]    active_notes;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [mcna_pkg::CH_W-1:0]     cfg_data = '0;

	// Predictor copy of the channel table and drum register
	logic [mcna_pkg::HELD_W-1:0]   tbl_note   [mcna_pkg::CHANNELS];
	logic [mcna_pkg::CH_W-1:0]     tbl_origin [mcna_pkg::CHANNELS];
	logic                          tbl_moved  [mcna_pkg::CHANNELS];
	logic [mcna_pkg::CH_W-1:0]     drum_ch;

	route_t                        pending_routes [$];
	played_t                       played_q [$];
	stim_row_t                     dir_tab [DIR_ROWS];
	logic [mcna_pkg::CH_W-1:0]     phase_drum [PHASES];
	int                            fail_count = 0;
	int                            burst_left = 0;
	route_t                        got_want;
	stall_mode_t                   stall_mode = STALL_NONE;
	int                            stall_left = 0;
	int                            stall_cyc = 0;

	midi_channel_note_allocator_top u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.event_kind      (event_kind),
		.channel         (channel),
		.note_number     (note_number),
		.velocity        (velocity),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_channel     (out_channel),
		.moved           (moved),
		.no_free_channel (no_free_channel),
		.active_notes    (active_notes),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Routes one event through the predictor table and returns the result.
	function automatic route_t route_event(input logic [mcna_pkg::KIND_W-1:0] kind,
			input logic [mcna_pkg::CH_W-1:0] ch, input logic [mcna_pkg::NOTE_W-1:0] note,
			input logic [mcna_pkg::VEL_W-1:0] vel);
		route_t r;
		int     k;
		int     c;
		bit     found;
		int     cnt;
		r.ch     = ch;
		r.mv     = 1'b0;
		r.nofree = 1'b0;
		found    = 1'b0;
		if ((kind == mcna_pkg::KIND_NOTE_ON || kind == mcna_pkg::KIND_NOTE_OFF) &&
				ch != drum_ch && ch < mcna_pkg::CHANNELS) begin
			if (kind == mcna_pkg::KIND_NOTE_ON && vel != 0) begin
				if (tbl_note[ch] == mcna_pkg::FREE_NOTE) begin
					tbl_note[ch]   = {1'b0, note};
					tbl_origin[ch] = ch;
					tbl_moved[ch]  = 1'b0;
				end else begin
					// round-robin search starting just past the busy channel
					for (k = 1; k < mcna_pkg::CHANNELS && !found; k++) begin
						c = (ch + k) % mcna_pkg::CHANNELS;
						if (c != drum_ch && tbl_note[c] == mcna_pkg::FREE_NOTE) begin
							tbl_note[c]   = {1'b0, note};
							tbl_origin[c] = ch;
							tbl_moved[c]  = 1'b1;
							r.ch  = mcna_pkg::CH_W'(c);
							r.mv  = 1'b1;
							found = 1'b1;
						end
					end
					if (!found)
						r.nofree = 1'b1;
				end
			end else begin
				// note-off: lowest moved entry of this origin and note wins
				for (c = 0; c < mcna_pkg::CHANNELS && !found; c++) begin
					if (tbl_note[c] != mcna_pkg::FREE_NOTE && tbl_moved[c] &&
							tbl_origin[c] == ch && tbl_note[c] == {1'b0, note}) begin
						tbl_note[c]   = mcna_pkg::FREE_NOTE;
						tbl_moved[c]  = 1'b0;
						tbl_origin[c] = '0;
						r.ch  = mcna_pkg::CH_W'(c);
						r.mv  = 1'b1;
						found = 1'b1;
					end
				end
				if (!found) begin
					tbl_note[ch]   = mcna_pkg::FREE_NOTE;
					tbl_moved[ch]  = 1'b0;
					tbl_origin[ch] = '0;
				end
			end
		end
		cnt = 0;
		for (c = 0; c < mcna_pkg::CHANNELS; c++)
			if (tbl_note[c] != mcna_pkg::FREE_NOTE)
				cnt++;
		r.act = mcna_pkg::ACT_W'(cnt);
		return r;
	endfunction

	function automatic stim_row_t mk_row(input logic [mcna_pkg::KIND_W-1:0] kind,
			input int ch, input int note, input int vel, input bit typed, input int och,
			input bit mv, input bit nf, input int act);
		stim_row_t s;
		s.kind        = kind;
		s.ch          = mcna_pkg::CH_W'(ch);
		s.note        = mcna_pkg::NOTE_W'(note);
		s.vel         = mcna_pkg::VEL_W'(vel);
		s.typed       = typed;
		s.want.ch     = mcna_pkg::CH_W'(och);
		s.want.mv     = mv;
		s.want.nofree = nf;
		s.want.act    = mcna_pkg::ACT_W'(act);
		return s;
	endfunction

	// One input transfer. Gaps open only between bursts, so valid is never
	// dropped and raised in the same step.
	task automatic send_event(input logic [mcna_pkg::KIND_W-1:0] kind,
			input logic [mcna_pkg::CH_W-1:0] ch, input logic [mcna_pkg::NOTE_W-1:0] note,
			input logic [mcna_pkg::VEL_W-1:0] vel, input bit typed, input route_t want);
		route_t r;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		event_kind  <= kind;
		channel     <= ch;
		note_number <= note;
		velocity    <= vel;
		in_valid    <= 1'b1;
		do @(posedge clk); while (in_stall);
		r = route_event(kind, ch, note, vel);
		pending_routes.push_back(typed ? want : r);
	endtask

	// Drum register write, only once every routed result has come back.
	task automatic write_drum(input logic [mcna_pkg::CH_W-1:0] val);
		in_valid   <= 1'b0;
		burst_left = 0;
		while (pending_routes.size() != 0) @(posedge clk);
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		drum_ch = val;
	endtask

	// Random event, mostly well-formed: note-ons crowd a few hot channels so
	// the table fills, note-offs mostly release something actually played.
	task automatic rand_event(input int on_pct);
		int                          roll;
		int                          idx;
		played_t                     p;
		logic [mcna_pkg::KIND_W-1:0] kind;
		logic [mcna_pkg::CH_W-1:0]   ch;
		logic [mcna_pkg::NOTE_W-1:0] note;
		logic [mcna_pkg::VEL_W-1:0]  vel;
		roll = $urandom_range(0, 99);
		if (roll < on_pct) begin
			kind = mcna_pkg::KIND_NOTE_ON;
			ch   = mcna_pkg::CH_W'(($urandom_range(0, 1) == 0) ?
				$urandom_range(0, 3) : $urandom);
			note = mcna_pkg::NOTE_W'($urandom);
			vel  = mcna_pkg::VEL_W'($urandom_range(1, 127));
			played_q.push_back({ch, note});
			if (played_q.size() > 48)
				void'(played_q.pop_front());
		end else if (roll < on_pct + 30 && played_q.size() != 0) begin
			idx = $urandom_range(0, played_q.size() - 1);
			p   = played_q[idx];
			played_q.delete(idx);
			ch   = p.ch;
			note = p.note;
			if ($urandom_range(0, 3) == 0) begin
				kind = mcna_pkg::KIND_NOTE_ON;
				vel  = '0;
			end else begin
				kind = mcna_pkg::KIND_NOTE_OFF;
				vel  = mcna_pkg::VEL_W'($urandom);
			end
		end else if (roll < 92) begin
			// stray note-off
			kind = mcna_pkg::KIND_NOTE_OFF;
			ch   = mcna_pkg::CH_W'($urandom);
			note = mcna_pkg::NOTE_W'($urandom);
			vel  = mcna_pkg::VEL_W'($urandom);
		end else begin
			kind = mcna_pkg::KIND_W'($urandom_range(KIND_RSVD, KIND_OTHER));
			ch   = mcna_pkg::CH_W'($urandom);
			note = mcna_pkg::NOTE_W'($urandom);
			vel  = mcna_pkg::VEL_W'($urandom);
		end
		send_event(kind, ch, note, vel, 1'b0, '0);
	endtask

	initial begin
		int i;
		int ph;
		int on_pct;
		for (i = 0; i < mcna_pkg::CHANNELS; i++) begin
			tbl_note[i]   = mcna_pkg::FREE_NOTE;
			tbl_origin[i] = '0;
			tbl_moved[i]  = 1'b0;
		end
		drum_ch = mcna_pkg::DRUM_RESET;

		// Directed rows run at the reset drum channel (9).
		// Pass-through: other, reserved, drum channel; then note-off on a free channel
		dir_tab[0]  = mk_row(KIND_OTHER,              3, 127, 127, 1,  3, 0, 0, 0);
		dir_tab[1]  = mk_row(KIND_RSVD,              15,   0,   0, 1, 15, 0, 0, 0);
		dir_tab[2]  = mk_row(mcna_pkg::KIND_NOTE_ON,  9,  60, 100, 1,  9, 0, 0, 0);
		dir_tab[3]  = mk_row(mcna_pkg::KIND_NOTE_OFF, 4,   7, 127, 1,  4, 0, 0, 0);
		// free channel, then a move, then a second copy of the same moved note
		dir_tab[4]  = mk_row(mcna_pkg::KIND_NOTE_ON,  0,   0, 127, 1,  0, 0, 0, 1);
		dir_tab[5]  = mk_row(mcna_pkg::KIND_NOTE_ON,  0,  50,   1, 1,  1, 1, 0, 2);
		dir_tab[6]  = mk_row(mcna_pkg::KIND_NOTE_ON,  0,  50,  64, 0,  0, 0, 0, 0);
		// fill the rest from channel 0, hopping over the drum channel
		for (i = 7; i < 19; i++)
			dir_tab[i] = mk_row(mcna_pkg::KIND_NOTE_ON, 0, i + 3, 40 + i, 0, 0, 0, 0, 0);
		// every channel busy: stays put, flagged
		dir_tab[19] = mk_row(mcna_pkg::KIND_NOTE_ON, 15, 127, 127, 1, 15, 0, 1, 15);
		// two moved matches: lowest first; velocity-0 note-on acts as note-off
		dir_tab[20] = mk_row(mcna_pkg::KIND_NOTE_OFF, 0,  50,   0, 0,  0, 0, 0, 0);
		dir_tab[21] = mk_row(mcna_pkg::KIND_NOTE_ON,  0,  50,   0, 0,  0, 0, 0, 0);
		// unmoved note-off frees its own channel whatever it holds
		dir_tab[22] = mk_row(mcna_pkg::KIND_NOTE_OFF, 0,  99,  77, 0,  0, 0, 0, 0);
		// search wraps past channel 15 back to channel 0
		dir_tab[23] = mk_row(mcna_pkg::KIND_NOTE_ON,  3,   5,  30, 0,  0, 0, 0, 0);
		// note held on channel 3 came from channel 0: no origin match
		dir_tab[24] = mk_row(mcna_pkg::KIND_NOTE_OFF, 3,  10, 127, 0,  0, 0, 0, 0);

		phase_drum[0] = 4'd0;
		phase_drum[1] = 4'd15;
		phase_drum[2] = mcna_pkg::CH_W'($urandom_range(1, 14));
		phase_drum[3] = mcna_pkg::DRUM_RESET;
		phase_drum[4] = mcna_pkg::CH_W'($urandom);
		phase_drum[5] = 4'd15;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < DIR_ROWS; i++)
			send_event(dir_tab[i].kind, dir_tab[i].ch, dir_tab[i].note, dir_tab[i].vel,
				dir_tab[i].typed, dir_tab[i].want);

		on_pct = 50;
		for (ph = 0; ph < PHASES; ph++) begin
			write_drum(phase_drum[ph]);
			for (i = 0; i < PHASE_ITEMS; i++) begin
				// density drifts so the table both fills up and drains
				if (i % 40 == 0)
					on_pct = $urandom_range(30, 62);
				rand_event(on_pct);
			end
		end

		in_valid <= 1'b0;
		while (pending_routes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("midi_channel_note_allocator_top test passed");
		else
			$display("midi_channel_note_allocator_top test failed");
		$finish;
	end

	// Receiver stall: modes switch at random intervals, including a
	// stretch with no stall at all and a fixed comb.
	always @(posedge clk) begin
		stall_cyc++;
		if (stall_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_left = $urandom_range(20, 150);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			STALL_NONE:  out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
			default:     out_stall <= (stall_cyc % 7) < 3;
		endcase
	end

	// Result checker: oldest expected route against each output transfer
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_routes.size() == 0) begin
				$display("%0t: unexpected result, out_channel %0d", $time, out_channel);
				fail_count++;
			end else begin
				got_want = pending_routes.pop_front();
				if (out_channel !== got_want.ch) begin
					$display("%0t: out_channel expected %0d got %0d", $time,
						got_want.ch, out_channel);
					fail_count++;
				end
				if (moved !== got_want.mv) begin
					$display("%0t: moved expected %0d got %0d", $time, got_want.mv, moved);
					fail_count++;
				end
				if (no_free_channel !== got_want.nofree) begin
					$display("%0t: no_free_channel expected %0d got %0d", $time,
						got_want.nofree, no_free_channel);
					fail_count++;
				end
				if (active_notes !== got_want.act) begin
					$display("%0t: active_notes expected %0d got %0d", $time,
						got_want.act, active_notes);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#TIMEOUT;
		$display("midi_channel_note_allocator_top test failed");
		$finish;
	end

endmodule
